>>> sv/assert_macros.svh
// assertion macros used by the checker file
// clocked on clk, with and without the reset disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define WESHU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WESHU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/weshu_pkg.sv
// types, widths and constants of the windowed energy stability halt unit
// no dependencies
package weshu_pkg;

  localparam int CHEM_W     = 16;
  localparam int EVAL_W     = 32;
  localparam int ENERGY_W   = 24;
  localparam int SQ_W       = 32;
  localparam int CELL_SUM_W = 40;
  localparam int LAT_SUM_W  = 32;
  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int MUL_W      = 24;
  localparam int PROD_W     = 48;
  localparam int THRESH_W   = 24;
  localparam int WLEN_W     = 7;
  localparam int LIMIT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [THRESH_W-1:0] THRESH_RST = 24'd256;
  localparam logic [WLEN_W-1:0]   WLEN_RST   = 7'd16;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 32'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 2'd0,
    CFG_WINDOW_LENGTH = 2'd1,
    CFG_STEP_LIMIT    = 2'd2
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_ctl_t;

  typedef struct packed {
    logic signed [CHEM_W-1:0] chemical;
    logic                     last_of_cell;
    logic                     last_of_lattice;
    logic [EVAL_W-1:0]        eval_num;
  } in_word_t;

  typedef struct packed {
    logic                stop;
    logic                window_full;
    logic [ENERGY_W-1:0] step_energy;
    logic [ENERGY_W-1:0] deviation;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CELL_ADD,
    ST_CELL_ROOT,
    ST_WAIT,
    ST_LAT_ADD,
    ST_STEP_ROOT,
    ST_ENERGY,
    ST_DROP_RD,
    ST_DROP_SUB,
    ST_PUSH,
    ST_TRIM,
    ST_MEAN,
    ST_VAR_INIT,
    ST_VAR_RD,
    ST_VAR_DIFF,
    ST_VAR_MUL,
    ST_VAR_ACC,
    ST_VAR_DIV,
    ST_DEV_ROOT,
    ST_DEV,
    ST_OUT
  } state_e;

endpackage

>>> sv/weshu_ram.sv
// generic single write port ram with registered read
// no dependencies
module weshu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/weshu_arith.sv
// shared bit-serial divide and square root unit, one result bit per cycle
// depends on weshu_pkg
module weshu_arith #(
  parameter int X_W = 54,
  parameter int D_W = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  weshu_pkg::arith_ctl_t ctl,
  input  logic [X_W-1:0]        operand,
  input  logic [D_W-1:0]        divisor,
  output logic                  done,
  output logic [X_W-1:0]        result
);
  import weshu_pkg::*;

  localparam int REM_W    = (D_W + 2 > ROOT_W + 3) ? D_W + 2 : ROOT_W + 3;
  localparam int STEP_W   = $clog2(X_W + 1);
  localparam int SQ_SHIFT = X_W - RAD_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  arith_op_e         op_r, op_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [X_W-1:0]    q_r, q_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [D_W-1:0]    div_r, div_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // shared trial subtract
  always_comb begin
    if (op_r == OP_SQRT) begin
      rem_sh = {rem_r[REM_W-3:0], x_r[X_W-1 -: 2]};
      trial  = REM_W'({q_r[ROOT_W-1:0], 2'b01});
    end else begin
      rem_sh = {rem_r[REM_W-2:0], x_r[X_W-1]};
      trial  = REM_W'(div_r);
    end
    fits = (rem_sh >= trial);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    step_nxt = step_r;
    x_nxt    = x_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      div_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      if (ctl.op == OP_SQRT) begin
        x_nxt    = operand << SQ_SHIFT;
        step_nxt = STEP_W'(ROOT_W);
      end else begin
        x_nxt    = operand;
        step_nxt = STEP_W'(X_W);
      end
    end else if (busy_r) begin
      rem_nxt  = fits ? rem_sh - trial : rem_sh;
      q_nxt    = {q_r[X_W-2:0], fits};
      x_nxt    = (op_r == OP_SQRT) ? {x_r[X_W-3:0], 2'b00} : {x_r[X_W-2:0], 1'b0};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    step_r <= step_nxt;
    x_r    <= x_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign done   = done_r;
  assign result = q_r;

endmodule

>>> sv/windowed_energy_stability_halt_unit.sv
// top level: cell and step energies, sliding window, deviation and halt decision
// depends on weshu_pkg, weshu_ram, weshu_arith
//
//   channel | ports                          | moves
//   --------+--------------------------------+-----------------------------
//   in      | in_valid in_ready in_data      | one chemical word
//   out     | out_valid out_ready out_data   | one result word per step end
//   cfg     | cfg_valid cfg_ready cfg_index  | one register write word
//           | cfg_data                       |
//
// a chemical inside a cell is squared and added to the cell sum; closing a cell adds a 24-step root
// a step end then adds the step root and the ring push before the window fills, and once it
// is full two divides, two roots and a pass over w ring entries;
// each dropped ring entry adds a read and a subtract
// reset clears control, the sums and the config registers; the ring ram is not cleared
// the result waits in an output register; new words are taken while it waits
module windowed_energy_stability_halt_unit #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  weshu_pkg::in_word_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output weshu_pkg::out_word_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [weshu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [weshu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import weshu_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = ENERGY_W + IDX_W;
  localparam int ACC_W = RAD_W + IDX_W;

  state_e                state_r, state_nxt;
  state_e                ret_r, ret_nxt;
  logic [CHEM_W-1:0]     mag_r, mag_nxt;
  logic                  end_cell_r, end_cell_nxt;
  logic                  end_lat_r, end_lat_nxt;
  logic [EVAL_W-1:0]     eval_r, eval_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [CELL_SUM_W-1:0] cell_sum_r, cell_sum_nxt;
  logic [LAT_SUM_W-1:0]  lat_sum_r, lat_sum_nxt;
  logic [ENERGY_W-1:0]   energy_r, energy_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SUM_W-1:0]      run_sum_r, run_sum_nxt;
  logic                  pushed_r, pushed_nxt;
  logic                  full_r, full_nxt;
  logic [ENERGY_W-1:0]   mean_r, mean_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [MUL_W-1:0]      diff_r, diff_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [ENERGY_W-1:0]   dev_r, dev_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;
  logic [THRESH_W-1:0]   threshold_r, threshold_nxt;
  logic [WLEN_W-1:0]     wlen_r, wlen_nxt;
  logic [LIMIT_W-1:0]    step_limit_r, step_limit_nxt;

  logic [CNT_W-1:0]      w_eff;
  logic [CNT_W:0]        back_diff;
  logic [CNT_W:0]        back_wrap;
  logic [IDX_W-1:0]      oldest;
  logic [CELL_SUM_W:0]   cell_add;
  logic [LAT_SUM_W:0]    lat_add;
  logic [MUL_W-1:0]      mul_in;
  logic [PROD_W-1:0]     mul_out;
  logic [ENERGY_W-1:0]   e_diff;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENERGY_W-1:0]   ram_rdata;
  arith_ctl_t            arith_ctl;
  logic [ACC_W-1:0]      arith_operand;
  logic                  arith_done;
  logic [ACC_W-1:0]      arith_res;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_W'(WINDOW_MAX - 1)) ? '0 : a + 1'b1;
  endfunction

  weshu_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (energy_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  weshu_arith #(
    .X_W (ACC_W),
    .D_W (CNT_W)
  ) u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (arith_ctl),
    .operand (arith_operand),
    .divisor (w_eff),
    .done    (arith_done),
    .result  (arith_res)
  );

  // effective window length
  always_comb begin
    if (wlen_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(wlen_r) > 32'(WINDOW_MAX)) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = CNT_W'(wlen_r);
    end
  end

  // oldest slot = head - count, modulo the ring depth
  assign back_diff = (CNT_W+1)'(head_r) - (CNT_W+1)'(count_r);
  assign back_wrap = back_diff[CNT_W] ? back_diff + (CNT_W+1)'(WINDOW_MAX) : back_diff;
  assign oldest    = back_wrap[IDX_W-1:0];

  assign cell_add = {1'b0, cell_sum_r} + (CELL_SUM_W+1)'(prod_r[SQ_W-1:0]);
  assign lat_add  = {1'b0, lat_sum_r} + (LAT_SUM_W+1)'(arith_res[ROOT_W-1:0]);
  assign mul_in   = (state_r == ST_SQUARE) ? MUL_W'(mag_r) : diff_r;
  assign mul_out  = mul_in * mul_in;
  assign e_diff   = (ram_rdata >= mean_r) ? ram_rdata - mean_r : mean_r - ram_rdata;

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    mag_nxt        = mag_r;
    end_cell_nxt   = end_cell_r;
    end_lat_nxt    = end_lat_r;
    eval_nxt       = eval_r;
    prod_nxt       = prod_r;
    cell_sum_nxt   = cell_sum_r;
    lat_sum_nxt    = lat_sum_r;
    energy_nxt     = energy_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    run_sum_nxt    = run_sum_r;
    pushed_nxt     = pushed_r;
    full_nxt       = full_r;
    mean_nxt       = mean_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    diff_nxt       = diff_r;
    acc_nxt        = acc_r;
    dev_nxt        = dev_r;
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    threshold_nxt  = threshold_r;
    wlen_nxt       = wlen_r;
    step_limit_nxt = step_limit_r;
    arith_ctl      = '{start: 1'b0, op: OP_SQRT};
    arith_operand  = '0;
    ram_we         = 1'b0;
    ram_raddr      = oldest;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD:     threshold_nxt  = cfg_data[THRESH_W-1:0];
        CFG_WINDOW_LENGTH: wlen_nxt       = cfg_data[WLEN_W-1:0];
        CFG_STEP_LIMIT:    step_limit_nxt = cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mag_nxt      = in_data.chemical[CHEM_W-1] ?
                         CHEM_W'(~in_data.chemical) + CHEM_W'(1) : CHEM_W'(in_data.chemical);
          end_cell_nxt = in_data.last_of_cell;
          end_lat_nxt  = in_data.last_of_lattice;
          eval_nxt     = in_data.eval_num;
          state_nxt    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        prod_nxt  = mul_out;
        state_nxt = ST_CELL_ADD;
      end
      ST_CELL_ADD: begin
        cell_sum_nxt = cell_add[CELL_SUM_W] ? '1 : cell_add[CELL_SUM_W-1:0];
        state_nxt    = (end_cell_r || end_lat_r) ? ST_CELL_ROOT : ST_IDLE;
      end
      ST_CELL_ROOT: begin
        arith_ctl.start = 1'b1;
        arith_operand   = ACC_W'(cell_sum_r);
        ret_nxt         = ST_LAT_ADD;
        state_nxt       = ST_WAIT;
      end
      ST_WAIT: begin
        if (arith_done) begin
          state_nxt = ret_r;
        end
      end
      ST_LAT_ADD: begin
        lat_sum_nxt  = lat_add[LAT_SUM_W] ? '1 : lat_add[LAT_SUM_W-1:0];
        cell_sum_nxt = '0;
        state_nxt    = end_lat_r ? ST_STEP_ROOT : ST_IDLE;
      end
      ST_STEP_ROOT: begin
        arith_ctl.start = 1'b1;
        arith_operand   = ACC_W'({lat_sum_r, 8'h00});
        ret_nxt         = ST_ENERGY;
        state_nxt       = ST_WAIT;
      end
      ST_ENERGY: begin
        energy_nxt  = arith_res[ENERGY_W-1:0];
        lat_sum_nxt = '0;
        pushed_nxt  = 1'b0;
        state_nxt   = (count_r == CNT_W'(WINDOW_MAX)) ? ST_DROP_RD : ST_PUSH;
      end
      ST_DROP_RD: begin
        state_nxt = ST_DROP_SUB;
      end
      ST_DROP_SUB: begin
        run_sum_nxt = run_sum_r - SUM_W'(ram_rdata);
        count_nxt   = count_r - 1'b1;
        state_nxt   = pushed_r ? ST_TRIM : ST_PUSH;
      end
      ST_PUSH: begin
        ram_we      = 1'b1;
        head_nxt    = wrap_inc(head_r);
        count_nxt   = count_r + 1'b1;
        run_sum_nxt = run_sum_r + SUM_W'(energy_r);
        pushed_nxt  = 1'b1;
        state_nxt   = ST_TRIM;
      end
      ST_TRIM: begin
        if (count_r > w_eff) begin
          state_nxt = ST_DROP_RD;
        end else if (count_r == w_eff) begin
          full_nxt  = 1'b1;
          state_nxt = ST_MEAN;
        end else begin
          full_nxt  = 1'b0;
          dev_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_MEAN: begin
        arith_ctl.start = 1'b1;
        arith_ctl.op    = OP_DIV;
        arith_operand   = ACC_W'(run_sum_r);
        ret_nxt         = ST_VAR_INIT;
        state_nxt       = ST_WAIT;
      end
      ST_VAR_INIT: begin
        mean_nxt  = arith_res[ENERGY_W-1:0];
        ptr_nxt   = oldest;
        idx_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = ST_VAR_RD;
      end
      ST_VAR_RD: begin
        ram_raddr = ptr_r;
        ptr_nxt   = wrap_inc(ptr_r);
        state_nxt = ST_VAR_DIFF;
      end
      ST_VAR_DIFF: begin
        diff_nxt  = e_diff;
        state_nxt = ST_VAR_MUL;
      end
      ST_VAR_MUL: begin
        prod_nxt  = mul_out;
        state_nxt = ST_VAR_ACC;
      end
      ST_VAR_ACC: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        idx_nxt   = idx_r + 1'b1;
        state_nxt = (CNT_W'(idx_r + 1'b1) == count_r) ? ST_VAR_DIV : ST_VAR_RD;
      end
      ST_VAR_DIV: begin
        arith_ctl.start = 1'b1;
        arith_ctl.op    = OP_DIV;
        arith_operand   = acc_r;
        ret_nxt         = ST_DEV_ROOT;
        state_nxt       = ST_WAIT;
      end
      ST_DEV_ROOT: begin
        arith_ctl.start = 1'b1;
        arith_operand   = ACC_W'(arith_res[RAD_W-1:0]);
        ret_nxt         = ST_DEV;
        state_nxt       = ST_WAIT;
      end
      ST_DEV: begin
        dev_nxt   = arith_res[ENERGY_W-1:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.stop        = full_r && ((dev_r < threshold_r) ||
                                                (eval_r >= step_limit_r));
          out_word_nxt.window_full = full_r;
          out_word_nxt.step_energy = energy_r;
          out_word_nxt.deviation   = dev_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      run_sum_r    <= '0;
      cell_sum_r   <= '0;
      lat_sum_r    <= '0;
      out_valid_r  <= 1'b0;
      threshold_r  <= THRESH_RST;
      wlen_r       <= WLEN_RST;
      step_limit_r <= LIMIT_RST;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      run_sum_r    <= run_sum_nxt;
      cell_sum_r   <= cell_sum_nxt;
      lat_sum_r    <= lat_sum_nxt;
      out_valid_r  <= out_valid_nxt;
      threshold_r  <= threshold_nxt;
      wlen_r       <= wlen_nxt;
      step_limit_r <= step_limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    mag_r      <= mag_nxt;
    end_cell_r <= end_cell_nxt;
    end_lat_r  <= end_lat_nxt;
    eval_r     <= eval_nxt;
    prod_r     <= prod_nxt;
    energy_r   <= energy_nxt;
    pushed_r   <= pushed_nxt;
    full_r     <= full_nxt;
    mean_r     <= mean_nxt;
    ptr_r      <= ptr_nxt;
    idx_r      <= idx_nxt;
    diff_r     <= diff_nxt;
    acc_r      <= acc_nxt;
    dev_r      <= dev_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

>>> sv/weshu_checker.sv
// port-level checks for the windowed energy stability halt unit, bound to the top level
// depends on weshu_pkg and assert_macros.svh
`include "assert_macros.svh"

module weshu_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input weshu_pkg::out_word_t out_data
);

  // stalled result word holds
  `WESHU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out word changed while stalled")

  // stop only with a full window
  `WESHU_ASSERT(a_stop_full, out_valid |-> !out_data.stop || out_data.window_full, "stop without full window")

  // deviation zero before the window fills
  `WESHU_ASSERT(a_dev_zero, out_valid && !out_data.window_full |-> out_data.deviation == 24'd0, "deviation nonzero before full")

  // one word at a time
  `WESHU_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready held after accept")

  // reset leaves no result and an idle input side
  `WESHU_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind windowed_energy_stability_halt_unit weshu_checker u_weshu_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for windowed_energy_stability_halt_unit: queued chemical words
// are driven, each step report is predicted in the bench and compared; uses weshu_pkg
module tb_top;
  import weshu_pkg::*;

  localparam int HIST_DEPTH = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN = 2'd3;
  localparam longint unsigned CELL_SAT = 64'hFF_FFFF_FFFF;
  localparam longint unsigned LAT_SAT = 64'hFFFF_FFFF;
  localparam longint unsigned FIELD_MAX = 64'hFF_FFFF;
  localparam int SETTLE_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  windowed_energy_stability_halt_unit #(
    .WINDOW_MAX(HIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  in_word_t chem_words[$];
  out_word_t step_reports[$];
  int bad_reports = 0;
  int words_queued = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  logic [THRESH_W-1:0] thresh_q = THRESH_RST;
  logic [WLEN_W-1:0] wlen_q = WLEN_RST;
  logic [LIMIT_W-1:0] limit_q = LIMIT_RST;
  logic [ENERGY_W-1:0] energy_hist [HIST_DEPTH];
  int unsigned hist_head = 0;
  int unsigned hist_count = 0;
  longint unsigned hist_sum = 0;
  longint unsigned cell_sq_acc = 0;
  longint unsigned lat_acc = 0;

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    int b;
    r = 0;
    for (b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic void drop_oldest_energy();
    int unsigned slot;
    slot = (hist_head + HIST_DEPTH - hist_count) % HIST_DEPTH;
    hist_sum -= 64'(energy_hist[slot]);
    hist_count--;
  endfunction

  function automatic longint unsigned eff_window();
    if (wlen_q == 0) return 1;
    if (wlen_q > HIST_DEPTH) return HIST_DEPTH;
    return 64'(wlen_q);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_THRESHOLD: thresh_q = val[THRESH_W-1:0];
      CFG_WINDOW_LENGTH: wlen_q = val[WLEN_W-1:0];
      CFG_STEP_LIMIT: limit_q = val[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // returns 1 when the word closes a lattice step and r holds the report
  function automatic bit compute_step_report(input in_word_t w, output out_word_t r);
    int c;
    longint unsigned mag, wl, mean, acc, d, e, root;
    int unsigned slot, k;
    r = '0;
    c = int'(w.chemical);
    mag = (c < 0) ? longint'(-c) : longint'(c);
    cell_sq_acc += mag * mag;
    if (cell_sq_acc > CELL_SAT) cell_sq_acc = CELL_SAT;
    if (!w.last_of_cell && !w.last_of_lattice) return 0;
    lat_acc += root_floor(cell_sq_acc);
    if (lat_acc > LAT_SAT) lat_acc = LAT_SAT;
    cell_sq_acc = 0;
    if (!w.last_of_lattice) return 0;
    root = root_floor(lat_acc << 8);
    if (root > FIELD_MAX) root = FIELD_MAX;
    r.step_energy = root[ENERGY_W-1:0];
    lat_acc = 0;
    wl = eff_window();
    if (hist_count >= HIST_DEPTH) drop_oldest_energy();
    energy_hist[hist_head] = r.step_energy;
    hist_head = (hist_head + 1) % HIST_DEPTH;
    hist_count++;
    hist_sum += 64'(r.step_energy);
    while (hist_count > wl) drop_oldest_energy();
    if (hist_count == wl) begin
      mean = hist_sum / wl;
      acc = 0;
      slot = (hist_head + HIST_DEPTH - hist_count) % HIST_DEPTH;
      for (k = 0; k < hist_count; k++) begin
        e = 64'(energy_hist[(slot + k) % HIST_DEPTH]);
        d = (e >= mean) ? e - mean : mean - e;
        acc += d * d;
      end
      root = root_floor(acc / wl);
      if (root > FIELD_MAX) root = FIELD_MAX;
      r.window_full = 1'b1;
      r.deviation = root[ENERGY_W-1:0];
      r.stop = (root < thresh_q) || (w.eval_num >= limit_q);
    end
    return 1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (chem_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= chem_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver with long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin : check_proc
    out_word_t want;
    out_word_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (step_reports.size() == 0) begin
          bad_reports++;
          if (bad_reports <= 10)
            $display("unexpected word: stop %0b full %0b energy %0d deviation %0d",
                     got.stop, got.window_full, got.step_energy, got.deviation);
        end else begin
          want = step_reports.pop_front();
          if (got.stop !== want.stop || got.window_full !== want.window_full ||
              got.step_energy !== want.step_energy || got.deviation !== want.deviation) begin
            bad_reports++;
            if (bad_reports <= 10)
              $display("mismatch: expected stop %0b full %0b energy %0d deviation %0d, %s",
                       want.stop, want.window_full, want.step_energy, want.deviation,
                       $sformatf("got stop %0b full %0b energy %0d deviation %0d",
                                 got.stop, got.window_full, got.step_energy,
                                 got.deviation));
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready && compute_step_report(in_data, want))
        step_reports = {step_reports, want};
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (chem_words.size() != 0 || in_valid || step_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_chem(input int c, input bit cell_end, input bit lat_end,
                           input logic [EVAL_W-1:0] ev);
    in_word_t w;
    w.chemical = c[CHEM_W-1:0];
    w.last_of_cell = cell_end;
    w.last_of_lattice = lat_end;
    w.eval_num = ev;
    chem_words = {chem_words, w};
    words_queued++;
  endtask

  function automatic int rand_chem();
    logic signed [CHEM_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = -16'sd32768;
      1: v = 16'sd32767;
      2: v = '0;
      3, 4: v = CHEM_W'($urandom_range(0, 1) ? $urandom_range(0, 511)
                                              : -$urandom_range(0, 511));
      default: v = CHEM_W'($urandom());
    endcase
    return int'(v);
  endfunction

  function automatic logic [EVAL_W-1:0] rand_eval();
    case ($urandom_range(0, 5))
      0: return limit_q - 1;
      1: return limit_q;
      2: return limit_q + 1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_step();
    int n_cells, n_chem, i, j;
    bit last;
    n_cells = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    for (i = 0; i < n_cells; i++) begin
      n_chem = $urandom_range(1, 4);
      for (j = 0; j < n_chem; j++) begin
        last = (i == n_cells - 1) && (j == n_chem - 1);
        if (last)
          push_chem(rand_chem(), $urandom_range(0, 3) != 0, 1'b1, rand_eval());
        else
          push_chem(rand_chem(), j == n_chem - 1, 1'b0, $urandom());
      end
    end
  endtask

  initial begin : stimulus
    int ph, k, r, target, flat_chem;
    logic [CFG_DATA_W-1:0] wl;
    for (k = 0; k < HIST_DEPTH; k++) energy_hist[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 48;
    @(negedge clk);

    write_reg(CFG_UNKNOWN, 32'h0000_0005);
    write_reg(CFG_WINDOW_LENGTH, 32'hFFFF_FF80);
    write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(CFG_STEP_LIMIT, 32'hFFFF_FFFF);
    push_chem(-32768, 1'b1, 1'b1, 32'h0);
    push_chem(32767, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_chem(0, 1'b1, 1'b1, 32'hFFFF_FFFE);
    // lattice end while the cell is still open
    push_chem(-1, 1'b0, 1'b0, 32'h0);
    push_chem(1, 1'b0, 1'b1, 32'h5555_5555);
    push_chem(256, 1'b1, 1'b0, 32'h0);
    push_chem(-256, 1'b1, 1'b0, 32'h0);
    push_chem(-32768, 1'b0, 1'b0, 32'h0);
    push_chem(12345, 1'b1, 1'b1, 32'hAAAA_AAAA);
    wait_idle();
    write_reg(CFG_THRESHOLD, 32'h0);
    write_reg(CFG_STEP_LIMIT, 32'h0);
    push_chem(-32768, 1'b1, 1'b1, 32'h0);
    push_chem(100, 1'b1, 1'b1, 32'h8000_0000);
    wait_idle();
    write_reg(CFG_WINDOW_LENGTH, 32'd127);
    write_reg(CFG_THRESHOLD, 32'd300);
    write_reg(CFG_STEP_LIMIT, 32'd1000);
    for (k = 0; k < 4; k++) push_chem(k * 3000 - 5000, 1'b1, 1'b1, k * 500);
    wait_idle();
    // shrink the window, then saturate the open cell sum
    write_reg(CFG_WINDOW_LENGTH, 32'd2);
    push_chem(-20000, 1'b1, 1'b1, 32'd999);
    push_chem(20000, 1'b1, 1'b1, 32'd1000);
    for (k = 0; k < 1030; k++) push_chem(-32768, 1'b0, 1'b0, $urandom());
    push_chem(-32768, 1'b1, 1'b1, 32'd7);
    wait_idle();
    write_reg(CFG_WINDOW_LENGTH, 32'd64);

    target = words_queued;
    for (ph = 0; ph < 3; ph++) begin
      wait_idle();
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 48 : 0;
      recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 25 : 0;
      write_reg(CFG_THRESHOLD, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1500));
      wl = (ph == 0) ? $urandom_range(2, 8) : (ph == 1) ? $urandom_range(60, 127)
                                                         : $urandom_range(0, 16);
      write_reg(CFG_WINDOW_LENGTH, ($urandom() & 32'hFFFF_FF80) | wl);
      write_reg(CFG_STEP_LIMIT, $urandom());
      flat_chem = rand_chem();
      if (ph == 0) begin
        hold_len = 4000;
        hold_req++;
      end
      target += (ph == 1) ? 200 : 100;
      while (words_queued < target) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          // identical steps drive the deviation to zero
          for (k = $urandom_range(1, eff_window() + 2); k > 0; k--)
            push_chem(flat_chem, 1'b1, 1'b1, rand_eval());
        end else if (r == 9) begin
          for (k = $urandom_range(1, 4); k > 0; k--)
            push_chem(rand_chem(), $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                      $urandom());
        end else begin
          add_step();
        end
      end
    end

    wait_idle();
    if (bad_reports == 0 && step_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
